// ===== rtl/core/lcbr_pkg.sv =====
package lcbr_pkg;

   // Default display size in pixels.
   localparam int DispWidthDef  = 128;
   localparam int DispHeightDef = 128;

   // Frame store geometry: one byte holds eight stacked pixels of one column.
   localparam int StoreDepth = 2048;
   localparam int AddrW      = 11;

   // Depth of the item queue between the front and the back.
   localparam int QueueDepth = 2;

   // Operation codes, decoded from the kind field by the front.
   localparam logic [1:0] OP_LINE   = 2'd0;
   localparam logic [1:0] OP_CIRCLE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   // One classified item as it waits in the queue.
   typedef struct packed {
      logic [1:0]       op;
      logic [7:0]       x_start;
      logic [7:0]       y_start;
      logic [7:0]       x_end;
      logic [7:0]       y_end;
      logic [7:0]       radius;
      logic             color;
      logic [AddrW-1:0] read_address;
   } item_type;

   // One pixel to plot, handed from the back to the store.
   typedef struct packed {
      logic       valid;
      logic [7:0] x;
      logic [7:0] y;
      logic       color;
   } pixel_type;

   // Byte read request from the back.
   typedef struct packed {
      logic             rd_en;
      logic [AddrW-1:0] rd_addr;
   } rd_req_type;

   // Store status seen by the front and the back.
   typedef struct packed {
      logic       clearing;
      logic       pipe_busy;
      logic [7:0] rd_data;
   } store_stat_type;

endpackage

// ===== rtl/core/line_circle_bitmap_rasterizer.sv =====
// Channel   Ports                               Handshake
// request   start, busy, req_*                  word taken when start and not busy
// response  rsp_strobe, rsp_read_data           single-cycle strobe per word, cannot be held off
//
// A line plots each pixel from start to end point; a circle checks its end test,
// then plots eight symmetric points per step; a byte read first waits for earlier
// pixel writes to land. The pixel read-modify-write on the frame store's write port
// sets one pixel per cycle. After reset the store is cleared one byte a cycle, with
// busy high. A two-word queue lets requests wait while the drawing engine works.
module line_circle_bitmap_rasterizer #(
   parameter int DISPLAY_WIDTH  = lcbr_pkg::DispWidthDef,
   parameter int DISPLAY_HEIGHT = lcbr_pkg::DispHeightDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_x_start,
   input  logic [7:0]  req_y_start,
   input  logic [7:0]  req_x_end,
   input  logic [7:0]  req_y_end,
   input  logic [7:0]  req_radius,
   input  logic        req_color,
   input  logic [10:0] req_read_address,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_read_data
);
   import lcbr_pkg::*;

   logic           item_valid;
   item_type       item;
   logic           item_pop;
   pixel_type      pix;
   rd_req_type     rd_req;
   store_stat_type stat;

   // Accepts and classifies request words.
   lcbr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_x_start      (req_x_start),
      .req_y_start      (req_y_start),
      .req_x_end        (req_x_end),
      .req_y_end        (req_y_end),
      .req_radius       (req_radius),
      .req_color        (req_color),
      .req_read_address (req_read_address),
      .clearing         (stat.clearing),
      .item_valid       (item_valid),
      .item             (item),
      .item_pop         (item_pop)
   );

   // Steps lines and circles and sequences reads.
   lcbr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop),
      .stat          (stat),
      .pix           (pix),
      .rd_req        (rd_req),
      .rsp_strobe    (rsp_strobe),
      .rsp_read_data (rsp_read_data)
   );

   // Frame store with the pixel update pipeline.
   lcbr_store #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .pix    (pix),
      .rd_req (rd_req),
      .stat   (stat)
   );

endmodule

// ===== rtl/core/lcbr_front.sv =====
module lcbr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_kind,
   input  logic [7:0]          req_x_start,
   input  logic [7:0]          req_y_start,
   input  logic [7:0]          req_x_end,
   input  logic [7:0]          req_y_end,
   input  logic [7:0]          req_radius,
   input  logic                req_color,
   input  logic [10:0]         req_read_address,
   input  logic                clearing,
   output logic                item_valid,
   output lcbr_pkg::item_type  item,
   input  logic                item_pop
);
   import lcbr_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

   item_type        q_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            push;
   logic            pop;
   item_type        new_item;

   // Classify the incoming word.
   always_comb begin
      new_item.x_start      = req_x_start;
      new_item.y_start      = req_y_start;
      new_item.x_end        = req_x_end;
      new_item.y_end        = req_y_end;
      new_item.radius       = req_radius;
      new_item.color        = req_color;
      new_item.read_address = req_read_address;
      case (req_kind)
         OP_LINE:   new_item.op = OP_LINE;
         OP_CIRCLE: new_item.op = OP_CIRCLE;
         OP_READ:   new_item.op = OP_READ;
         default:   new_item.op = OP_NOP;
      endcase
   end

   // The front stalls when the queue is full or the store is being cleared.
   assign busy       = (cnt_ff == FullCnt) || clearing;
   assign push       = start && !busy;
   assign item_valid = (cnt_ff != '0);
   assign pop        = item_pop && item_valid;
   assign item       = q_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue entries hold payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== rtl/core/lcbr_back.sv =====
module lcbr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_valid,
   input  lcbr_pkg::item_type         item,
   output logic                       item_pop,
   input  lcbr_pkg::store_stat_type   stat,
   output lcbr_pkg::pixel_type        pix,
   output lcbr_pkg::rd_req_type       rd_req,
   output logic                       rsp_strobe,
   output logic [7:0]                 rsp_read_data
);
   import lcbr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LINE  = 3'd1;
   localparam logic [2:0] ST_CTEST = 3'd2;
   localparam logic [2:0] ST_CPLOT = 3'd3;
   localparam logic [2:0] ST_RWAIT = 3'd4;
   localparam logic [2:0] ST_RDATA = 3'd5;

   localparam logic signed [13:0] DInit = 14'sd3;
   localparam logic signed [13:0] DInc0 = 14'sd6;
   localparam logic signed [13:0] DInc1 = 14'sd10;
   localparam logic [2:0]         LastOct = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [7:0]          px_ff, px_in, py_ff, py_in, qx_ff, qx_in, qy_ff, qy_in;
   logic signed [11:0]  dx_ff, dx_in, dy_ff, dy_in, err_ff, err_in;
   logic                sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic [7:0]          cx_ff, cx_in, cy_ff, cy_in;
   logic signed [9:0]   ox_ff, ox_in, oy_ff, oy_in;
   logic signed [13:0]  d_ff, d_in;
   logic [2:0]          oct_ff, oct_in;
   logic                color_ff, color_in;
   logic [AddrW-1:0]    raddr_ff, raddr_in;
   pixel_type           pix_ff, pix_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]          rsp_data_ff, rsp_data_in;

   logic [7:0]          abs_dx, abs_dy;
   logic signed [12:0]  e2;
   logic                step_x, step_y;
   logic [7:0]          ux, uy, cpx, cpy;
   logic signed [13:0]  ox_w, oy_w;

   // Line setup terms from the head of the queue.
   assign abs_dx = (item.x_end >= item.x_start) ? item.x_end - item.x_start
                                                : item.x_start - item.x_end;
   assign abs_dy = (item.y_end >= item.y_start) ? item.y_end - item.y_start
                                                : item.y_start - item.y_end;

   // Bresenham line decisions.
   assign e2     = {err_ff, 1'b0};
   assign step_x = e2 >= 13'(dy_ff);
   assign step_y = e2 <= 13'(dx_ff);

   // Eight-way symmetric circle point for the current octant.
   assign ux   = ox_ff[7:0];
   assign uy   = oy_ff[7:0];
   assign ox_w = 14'(ox_ff);
   assign oy_w = 14'(oy_ff);

   always_comb begin
      case (oct_ff)
         3'd0:    begin cpx = cx_ff + ux; cpy = cy_ff + uy; end
         3'd1:    begin cpx = cx_ff - ux; cpy = cy_ff + uy; end
         3'd2:    begin cpx = cx_ff + ux; cpy = cy_ff - uy; end
         3'd3:    begin cpx = cx_ff - ux; cpy = cy_ff - uy; end
         3'd4:    begin cpx = cx_ff + uy; cpy = cy_ff + ux; end
         3'd5:    begin cpx = cx_ff - uy; cpy = cy_ff + ux; end
         3'd6:    begin cpx = cx_ff + uy; cpy = cy_ff - ux; end
         default: begin cpx = cx_ff - uy; cpy = cy_ff - ux; end
      endcase
   end

   // Sequencer for lines, circles and byte reads.
   always_comb begin
      state_in      = state_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      err_in        = err_ff;
      sx_neg_in     = sx_neg_ff;
      sy_neg_in     = sy_neg_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      ox_in         = ox_ff;
      oy_in         = oy_ff;
      d_in          = d_ff;
      oct_in        = oct_ff;
      color_in      = color_ff;
      raddr_in      = raddr_ff;
      pix_in        = pix_ff;
      pix_in.valid  = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      item_pop      = 1'b0;
      rd_req        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid && !stat.clearing) begin
               item_pop  = 1'b1;
               color_in  = item.color;
               px_in     = item.x_start;
               py_in     = item.y_start;
               qx_in     = item.x_end;
               qy_in     = item.y_end;
               dx_in     = 12'(abs_dx);
               dy_in     = -12'(abs_dy);
               err_in    = 12'(abs_dx) - 12'(abs_dy);
               sx_neg_in = !(item.x_start < item.x_end);
               sy_neg_in = !(item.y_start < item.y_end);
               cx_in     = item.x_start;
               cy_in     = item.y_start;
               ox_in     = '0;
               oy_in     = 10'(item.radius);
               d_in      = DInit - 14'({item.radius, 1'b0});
               raddr_in  = item.read_address;
               case (item.op)
                  OP_LINE:   state_in = ST_LINE;
                  OP_CIRCLE: state_in = ST_CTEST;
                  OP_READ:   state_in = ST_RWAIT;
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_data_in   = '0;
                  end
               endcase
            end
         end
         ST_LINE: begin
            pix_in.valid = 1'b1;
            pix_in.x     = px_ff;
            pix_in.y     = py_ff;
            pix_in.color = color_ff;
            if (px_ff == qx_ff && py_ff == qy_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '0;
               state_in      = ST_IDLE;
            end else begin
               err_in = err_ff + (step_x ? dy_ff : 12'sd0) + (step_y ? dx_ff : 12'sd0);
               if (step_x) begin
                  px_in = sx_neg_ff ? px_ff - 1'b1 : px_ff + 1'b1;
               end
               if (step_y) begin
                  py_in = sy_neg_ff ? py_ff - 1'b1 : py_ff + 1'b1;
               end
            end
         end
         ST_CTEST: begin
            oct_in = '0;
            if (ox_ff <= oy_ff) begin
               state_in = ST_CPLOT;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '0;
               state_in      = ST_IDLE;
            end
         end
         ST_CPLOT: begin
            pix_in.valid = 1'b1;
            pix_in.x     = cpx;
            pix_in.y     = cpy;
            pix_in.color = color_ff;
            oct_in       = oct_ff + 1'b1;
            if (oct_ff == LastOct) begin
               // Advance the Bresenham circle decision once all eight points are out.
               if (d_ff < 0) begin
                  d_in = d_ff + (ox_w <<< 2) + DInc0;
               end else begin
                  d_in  = d_ff + ((ox_w - oy_w) <<< 2) + DInc1;
                  oy_in = oy_ff - 10'sd1;
               end
               ox_in    = ox_ff + 10'sd1;
               state_in = ST_CTEST;
            end
         end
         ST_RWAIT: begin
            // Earlier pixel writes must land before the byte is read.
            if (!pix_ff.valid && !stat.pipe_busy) begin
               rd_req.rd_en   = 1'b1;
               rd_req.rd_addr = raddr_ff;
               state_in       = ST_RDATA;
            end
         end
         ST_RDATA: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = stat.rd_data;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers; the pixel word is held during reset apart from its valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pix_ff.valid  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pix_ff        <= pix_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      py_ff        <= py_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      err_ff       <= err_in;
      sx_neg_ff    <= sx_neg_in;
      sy_neg_ff    <= sy_neg_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      ox_ff        <= ox_in;
      oy_ff        <= oy_in;
      d_ff         <= d_in;
      oct_ff       <= oct_in;
      color_ff     <= color_in;
      raddr_ff     <= raddr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign pix           = pix_ff;
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

// ===== rtl/core/lcbr_store.sv =====
module lcbr_store #(
   parameter int DISPLAY_WIDTH  = lcbr_pkg::DispWidthDef,
   parameter int DISPLAY_HEIGHT = lcbr_pkg::DispHeightDef
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lcbr_pkg::pixel_type        pix,
   input  lcbr_pkg::rd_req_type       rd_req,
   output lcbr_pkg::store_stat_type   stat
);
   import lcbr_pkg::*;

   localparam logic [8:0]       WidthLim  = 9'(DISPLAY_WIDTH);
   localparam logic [8:0]       HeightLim = 9'(DISPLAY_HEIGHT);
   localparam logic [6:0]       TopRow    = 7'(DISPLAY_HEIGHT - 1);
   localparam logic [11:0]      PageStep  = 12'(DISPLAY_WIDTH);
   localparam logic [AddrW-1:0] LastIdx   = AddrW'(StoreDepth - 1);

   logic [7:0]       mem [StoreDepth];
   logic [7:0]       mem_q_ff;

   logic             in_range;
   logic [6:0]       row;
   logic [11:0]      idx_full;
   logic [AddrW-1:0] pix_idx;
   logic [7:0]       pix_mask;
   logic [AddrW-1:0] rd_addr;

   logic             p2_valid_ff, p2_valid_in;
   logic [AddrW-1:0] p2_idx_ff;
   logic [7:0]       p2_mask_ff;
   logic             p2_color_ff;
   logic             wr_valid_ff;
   logic [AddrW-1:0] wr_idx_ff;
   logic [7:0]       wr_data_ff;
   logic [7:0]       base;
   logic [7:0]       new_byte;

   logic             clr_ff, clr_in;
   logic [AddrW-1:0] clr_cnt_ff, clr_cnt_in;

   // Pixel to byte address and bit, with the row flip and the bounds check.
   assign in_range = pix.valid && ({1'b0, pix.x} < WidthLim) && ({1'b0, pix.y} < HeightLim);
   assign row      = TopRow - pix.y[6:0];
   assign idx_full = 12'(row[6:3]) * PageStep + 12'(pix.x);
   assign pix_idx  = idx_full[AddrW-1:0];
   assign pix_mask = 8'd1 << row[2:0];
   assign rd_addr  = rd_req.rd_en ? rd_req.rd_addr : pix_idx;
   assign p2_valid_in = in_range;

   // Modify stage; the last written byte, held in the write stage, is forwarded.
   assign base     = (wr_valid_ff && wr_idx_ff == p2_idx_ff) ? wr_data_ff : mem_q_ff;
   assign new_byte = p2_color_ff ? (base | p2_mask_ff) : (base & ~p2_mask_ff);

   // Clearing pass after reset.
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LastIdx) begin
            clr_in = 1'b0;
         end
      end
   end

   // Frame store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (p2_valid_ff) begin
         mem[p2_idx_ff] <= new_byte;
      end
      mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_cnt_ff  <= '0;
         p2_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         clr_ff      <= clr_in;
         clr_cnt_ff  <= clr_cnt_in;
         p2_valid_ff <= p2_valid_in;
         wr_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_idx_ff   <= pix_idx;
      p2_mask_ff  <= pix_mask;
      p2_color_ff <= pix.color;
      wr_idx_ff   <= p2_idx_ff;
      wr_data_ff  <= new_byte;
   end

   assign stat.clearing  = clr_ff;
   assign stat.pipe_busy = pix.valid || p2_valid_ff;
   assign stat.rd_data   = mem_q_ff;

endmodule
